@@ src/lruc_pkg.sv @@
// Shared constants and types for the LRU cache hit/miss tracker.
package lruc_pkg;

   localparam int ENTRIES_DEFAULT  = 16;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic hit;
      logic full;
   } lookup_type;

endpackage

@@ src/lruc_lookup.sv @@
// Parallel tag compare, free slot pick and LRU victim select.
module lruc_lookup #(
   parameter int ENTRIES  = lruc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEFAULT,
   parameter int AGE_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int FILL_W   = $clog2(ENTRIES + 1)
) (
   input  logic [KEY_BITS-1:0]                key,
   input  logic [ENTRIES-1:0][KEY_BITS-1:0]   slot_key,
   input  logic [ENTRIES-1:0]                 slot_valid,
   input  logic [ENTRIES-1:0][AGE_W-1:0]      slot_age,
   input  logic [FILL_W-1:0]                  fill_count,
   input  logic [lruc_pkg::CAP_W-1:0]         capacity,
   output lruc_pkg::lookup_type               look,
   output logic [ENTRIES-1:0]                 target,
   output logic [AGE_W-1:0]                   hit_age
);

   localparam int CMP_W = (FILL_W > lruc_pkg::CAP_W) ? FILL_W : lruc_pkg::CAP_W;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_first;
   logic [AGE_W-1:0]   oldest_age;
   logic [CMP_W-1:0]   cap_raw;
   logic [CMP_W-1:0]   cap_eff;

   assign oldest_age = AGE_W'(fill_count - 1'b1);

   always_comb begin
      hit_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = slot_valid[i] && (slot_key[i] == key);
         victim[i] = slot_valid[i] && (slot_age[i] == oldest_age);
         hit_age   = hit_age | (slot_age[i] & {AGE_W{match[i]}});
      end
   end

   // lowest free slot, isolated as one-hot
   assign free_vec   = ~slot_valid;
   assign free_first = free_vec & (~free_vec + 1'b1);

   always_comb begin
      cap_raw = CMP_W'(capacity);
      if (cap_raw == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_raw > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_raw;
      end
   end

   assign look.hit  = |match;
   assign look.full = CMP_W'(fill_count) >= cap_eff;

   always_comb begin
      priority if (look.hit) begin
         target = match;
      end else if (look.full) begin
         target = victim;
      end else begin
         target = free_first;
      end
   end

endmodule

@@ src/lruc_slots.sv @@
// Slot tags, valid bits, age ranks and fill count with their update.
module lruc_slots #(
   parameter int ENTRIES  = lruc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEFAULT,
   parameter int AGE_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int FILL_W   = $clog2(ENTRIES + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               upd_valid,
   input  logic [KEY_BITS-1:0]                key,
   input  lruc_pkg::lookup_type               look,
   input  logic [ENTRIES-1:0]                 target,
   input  logic [AGE_W-1:0]                   hit_age,
   output logic [ENTRIES-1:0][KEY_BITS-1:0]   slot_key,
   output logic [ENTRIES-1:0]                 slot_valid,
   output logic [ENTRIES-1:0][AGE_W-1:0]      slot_age,
   output logic [FILL_W-1:0]                  fill_count
);

   logic [ENTRIES-1:0][KEY_BITS-1:0] key_ff;
   logic [ENTRIES-1:0][KEY_BITS-1:0] key_in;
   logic [ENTRIES-1:0]               valid_ff;
   logic [ENTRIES-1:0]               valid_in;
   logic [ENTRIES-1:0][AGE_W-1:0]    age_ff;
   logic [ENTRIES-1:0][AGE_W-1:0]    age_in;
   logic [FILL_W-1:0]                fill_ff;
   logic [FILL_W-1:0]                fill_in;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      age_in   = age_ff;
      fill_in  = fill_ff;
      if (clear) begin
         valid_in = '0;
         fill_in  = '0;
      end else if (upd_valid) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (target[i]) begin
               age_in[i]   = '0;
               valid_in[i] = 1'b1;
               if (!look.hit) begin
                  key_in[i] = key;
               end
            end else if (valid_ff[i] && (!look.hit || age_ff[i] < hit_age)) begin
               age_in[i] = age_ff[i] + 1'b1;
            end
         end
         if (!look.hit && !look.full) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      age_ff <= age_in;
   end

   assign slot_key   = key_ff;
   assign slot_valid = valid_ff;
   assign slot_age   = age_ff;
   assign fill_count = fill_ff;

endmodule

@@ src/lru_cache_hit_miss_top.sv @@
// Top level of the fully associative LRU cache hit/miss tracker.
// Takes one key per cycle (start while busy is low) and returns one item per key:
// rsp_miss on rsp_strobe, registered through req_valid_ff and rsp_strobe_ff, for
// exactly one cycle; the receiver cannot stall it. The key is registered, then
// compared against all slots and the tag, valid and age registers are updated in
// the next cycle, which also loads the result register. busy is high only during
// reset. A write on csr_we sets the capacity and empties the cache; write it
// only while no item is in flight.
module lru_cache_hit_miss_top #(
   parameter int ENTRIES  = lruc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [KEY_BITS-1:0]  req_key,
   output logic                        rsp_strobe,
   output logic                        rsp_miss,
   input  logic                        csr_we,
   input  logic [lruc_pkg::CAP_W-1:0]  csr_wdata
);

   localparam int AGE_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);

   logic                             req_valid_ff;
   logic [KEY_BITS-1:0]              req_key_ff;
   logic [lruc_pkg::CAP_W-1:0]       capacity_ff;
   logic                             rsp_strobe_ff;
   logic                             rsp_miss_ff;

   logic [ENTRIES-1:0][KEY_BITS-1:0] slot_key;
   logic [ENTRIES-1:0]               slot_valid;
   logic [ENTRIES-1:0][AGE_W-1:0]    slot_age;
   logic [FILL_W-1:0]                fill_count;
   lruc_pkg::lookup_type             look;
   logic [ENTRIES-1:0]               target;
   logic [AGE_W-1:0]                 hit_age;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         capacity_ff   <= lruc_pkg::CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= start;
         rsp_strobe_ff <= req_valid_ff;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_key_ff  <= req_key;
      rsp_miss_ff <= !look.hit;
   end

   lruc_lookup #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .AGE_W    (AGE_W),
      .FILL_W   (FILL_W)
   ) u_lookup (
      .key        (req_key_ff),
      .slot_key   (slot_key),
      .slot_valid (slot_valid),
      .slot_age   (slot_age),
      .fill_count (fill_count),
      .capacity   (capacity_ff),
      .look       (look),
      .target     (target),
      .hit_age    (hit_age)
   );

   lruc_slots #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .AGE_W    (AGE_W),
      .FILL_W   (FILL_W)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .clear      (csr_we),
      .upd_valid  (req_valid_ff),
      .key        (req_key_ff),
      .look       (look),
      .target     (target),
      .hit_age    (hit_age),
      .slot_key   (slot_key),
      .slot_valid (slot_valid),
      .slot_age   (slot_age),
      .fill_count (fill_count)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_miss   = rsp_miss_ff;

endmodule
